>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the lfo block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, idle while reset is asserted
`define CSTL_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, idle while reset is asserted
`define CSTL_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed: next-cycle implication");

`else

`define CSTL_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define CSTL_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

>>> rtl/core/cstl_pkg.sv
// shared types, widths, codes and reset constants of the lfo block
`default_nettype none

package cstl_pkg;

	localparam int CMD_W      = 2;
	localparam int PHASE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int INC_W      = 31;
	localparam int TICKS_W    = 20;
	localparam int RATIO_W    = 7;
	localparam int ECNT_W     = 13;
	localparam int RATIO_MAX  = 64;
	localparam int PROD_W     = TICKS_W + RATIO_W;
	localparam int DIV_W      = INC_W;
	localparam int DVS_W      = PROD_W - 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ECNT_W-1:0]  ECNT_MAX   = '1;
	localparam logic [INC_W-1:0]   Q31_TOP    = '1;
	localparam logic [PHASE_W-1:0] PHASE_MIN  = {1'b1, {(PHASE_W-1){1'b0}}};
	localparam logic [PHASE_W-1:0] SNAP_LIMIT = PHASE_W'(Q31_TOP / 31'd40);

	// command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLOCK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SET    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_INC    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_DEN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NO_SLOWDOWN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS   = 3'd6;

	// reset configuration and what follows from it
	localparam logic [TICKS_W-1:0] RST_TICKS     = 20'd500;
	localparam logic [TICKS_W-1:0] RST_MIN_TICKS = 20'd4;
	localparam logic [RATIO_W-1:0] RST_RATIO     = 7'd1;
	localparam logic [ECNT_W-1:0]  RST_DELAY     = 13'd1;
	localparam logic [INC_W-1:0]   RST_INC   = INC_W'(Q31_TOP / (RST_TICKS / 20'd2));
	localparam logic [PHASE_W-1:0] RST_FAST  = {RST_INC, 1'b0};
	localparam logic [PHASE_W-1:0] RST_SLOW  =
		PHASE_W'(RST_INC >> 1) + PHASE_W'(RST_INC[0]);

	// classified command as it travels from front to back
	typedef struct packed {
		logic                 sample;
		logic                 clk_edge;
		logic                 rst_ph;
		logic                 set_ph;
		logic [PHASE_W-1:0]   phase;
	} op_t;

	// settings the back end works from
	typedef struct packed {
		logic                 sync;
		logic                 corr_en;
		logic [ECNT_W-1:0]    delay;
		logic [INC_W-1:0]     inc;
		logic [PHASE_W-1:0]   step_fast;
		logic [PHASE_W-1:0]   step_slow;
	} cfg_info_t;

endpackage

`default_nettype wire

>>> rtl/core/cstl_in_if.sv
// command channel of the lfo block
`default_nettype none

interface cstl_in_if import cstl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           command;
	logic signed [PHASE_W-1:0]  phase_value;

	modport source (output valid, output command, output phase_value, input ready);
	modport sink   (input valid, input command, input phase_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cstl_out_if.sv
// result channel of the lfo block
`default_nettype none

interface cstl_out_if import cstl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [PHASE_W-1:0]  triangle;
	logic                       square;

	modport source (output valid, output triangle, output square, input ready);
	modport sink   (input valid, input triangle, input square, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cstl_cfg_if.sv
// register write channel of the lfo block
`default_nettype none

interface cstl_cfg_if import cstl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cstl_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module cstl_div import cstl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DVS_W-1:0]  divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0]    trial;
	logic              ge;
	logic [DVS_W:0]    diff;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/cstl_cfg.sv
// register file and increment sequencer of the lfo block
`default_nettype none

module cstl_cfg import cstl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cstl_cfg_if.sink    cfg,
	output cfg_info_t   info,
	output logic        busy
);

	localparam logic [2:0] SEQ_IDLE   = 3'd0;
	localparam logic [2:0] SEQ_NORM   = 3'd1;
	localparam logic [2:0] SEQ_PROD   = 3'd2;
	localparam logic [2:0] SEQ_D1GO   = 3'd3;
	localparam logic [2:0] SEQ_D1RUN  = 3'd4;
	localparam logic [2:0] SEQ_D2GO   = 3'd5;
	localparam logic [2:0] SEQ_D2RUN  = 3'd6;
	localparam logic [2:0] SEQ_SETTLE = 3'd7;

	function automatic logic [RATIO_W-1:0] norm_ratio(input logic [RATIO_W-1:0] r);
		logic [RATIO_W-1:0] v;
		v = r;
		if (r == '0) begin
			v = RATIO_W'(1);
		end else if (int'(r) > RATIO_MAX) begin
			v = RATIO_W'(RATIO_MAX);
		end
		return v;
	endfunction

	logic                 sync_q;
	logic [INC_W-1:0]     free_q;
	logic [TICKS_W-1:0]   ticks_q;
	logic [RATIO_W-1:0]   num_q;
	logic [RATIO_W-1:0]   den_q;
	logic                 nslow_q;
	logic [TICKS_W-1:0]   min_q;

	logic [RATIO_W-1:0]   n_q;
	logic [RATIO_W-1:0]   d_q;
	logic [ECNT_W-1:0]    delay_q;
	logic                 corr_q;
	logic [INC_W-1:0]     inc_q;
	logic [PHASE_W-1:0]   fast_q;
	logic [PHASE_W-1:0]   slow_q;

	logic [2:0]           seq_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DVS_W-1:0]     half_q;

	logic                 wr;
	logic [2*RATIO_W-1:0] nd;
	logic [ECNT_W-1:0]    delay_d;
	logic                 div_start;
	logic [DIV_W-1:0]     div_dividend;
	logic [DVS_W-1:0]     div_divisor;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quo;
	logic [DVS_W-1:0]     quo_half;

	assign busy      = seq_q != SEQ_IDLE;
	assign cfg.ready = !busy;
	assign wr        = cfg.valid && cfg.ready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q  <= 1'b1;
			free_q  <= '0;
			ticks_q <= RST_TICKS;
			num_q   <= RST_RATIO;
			den_q   <= RST_RATIO;
			nslow_q <= 1'b0;
			min_q   <= RST_MIN_TICKS;
		end else if (wr) begin
			unique case (cfg.index)
				REG_SYNC_MODE:   sync_q  <= cfg.data[0];
				REG_FREE_INC:    free_q  <= cfg.data[INC_W-1:0];
				REG_CLOCK_TICKS: begin
					// zero ticks would mean an infinite period, stored as one
					ticks_q <= (cfg.data[TICKS_W-1:0] == '0) ? TICKS_W'(1)
						: cfg.data[TICKS_W-1:0];
				end
				REG_RATIO_NUM:   num_q   <= cfg.data[RATIO_W-1:0];
				REG_RATIO_DEN:   den_q   <= cfg.data[RATIO_W-1:0];
				REG_NO_SLOWDOWN: nslow_q <= cfg.data[0];
				REG_MIN_TICKS:   min_q   <= cfg.data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// edge reset interval: one edge when d is one, else n*d saturated
	always_comb begin
		nd = n_q * d_q;
		if (d_q == RATIO_W'(1)) begin
			delay_d = ECNT_W'(1);
		end else if (nd > (2*RATIO_W)'(ECNT_MAX)) begin
			delay_d = ECNT_MAX;
		end else begin
			delay_d = nd[ECNT_W-1:0];
		end
	end

	// derived settings, refreshed every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= RST_RATIO;
			d_q     <= RST_RATIO;
			delay_q <= RST_DELAY;
			corr_q  <= 1'b1;
			fast_q  <= RST_FAST;
			slow_q  <= RST_SLOW;
		end else begin
			n_q     <= norm_ratio(num_q);
			d_q     <= norm_ratio(den_q);
			delay_q <= delay_d;
			corr_q  <= sync_q && (ticks_q > min_q);
			fast_q  <= {inc_q, 1'b0};
			slow_q  <= nslow_q ? {inc_q, 1'b0}
				: PHASE_W'(inc_q[INC_W-1:1]) + PHASE_W'(inc_q[0]);
		end
	end

	// increment sequencer: ticks*d/n, then top/(that quotient/2) in sync mode; the free increment otherwise
	assign div_start    = (seq_q == SEQ_D1GO) || (seq_q == SEQ_D2GO);
	assign div_dividend = (seq_q == SEQ_D1GO) ? DIV_W'(prod_q) : Q31_TOP;
	assign div_divisor  = (seq_q == SEQ_D1GO) ? DVS_W'(n_q) : half_q;
	assign quo_half     = div_quo[PROD_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
			inc_q <= RST_INC;
		end else begin
			unique case (seq_q)
				SEQ_IDLE:   if (wr) seq_q <= SEQ_NORM;
				SEQ_NORM:   seq_q <= SEQ_PROD;
				SEQ_PROD: begin
					if (sync_q) begin
						seq_q <= SEQ_D1GO;
					end else begin
						inc_q <= free_q;
						seq_q <= SEQ_SETTLE;
					end
				end
				SEQ_D1GO:   seq_q <= SEQ_D1RUN;
				SEQ_D1RUN: begin
					if (div_done) begin
						if (quo_half == '0) begin
							// zero divisor saturates the step
							inc_q <= Q31_TOP;
							seq_q <= SEQ_SETTLE;
						end else begin
							seq_q <= SEQ_D2GO;
						end
					end
				end
				SEQ_D2GO:   seq_q <= SEQ_D2RUN;
				SEQ_D2RUN: begin
					if (div_done) begin
						inc_q <= div_quo;
						seq_q <= SEQ_SETTLE;
					end
				end
				SEQ_SETTLE: seq_q <= SEQ_IDLE;
				default:    seq_q <= SEQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_PROD) begin
			prod_q <= PROD_W'(ticks_q) * PROD_W'(d_q);
		end
		if ((seq_q == SEQ_D1RUN) && div_done) begin
			half_q <= quo_half;
		end
	end

	cstl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		info.sync      = sync_q;
		info.corr_en   = corr_q;
		info.delay     = delay_q;
		info.inc       = inc_q;
		info.step_fast = fast_q;
		info.step_slow = slow_q;
	end

endmodule

`default_nettype wire

>>> rtl/core/cstl_front.sv
// front end: takes commands and classifies them for the queue
`default_nettype none

module cstl_front import cstl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cstl_in_if.sink   item,
	input  logic      busy,
	output logic      push_valid,
	output op_t       push_op,
	input  logic      push_ready
);

	logic  vld_s1;
	op_t   op_s1;
	op_t   op_d;
	logic  take;
	logic  move;

	assign move       = !vld_s1 || push_ready;
	assign item.ready = !busy && move;
	assign take       = item.valid && item.ready;

	always_comb begin
		op_d = '0;
		unique case (item.command)
			CMD_SAMPLE: op_d.sample   = 1'b1;
			CMD_CLOCK:  op_d.clk_edge = 1'b1;
			CMD_RESET:  op_d.rst_ph   = 1'b1;
			CMD_SET: begin
				op_d.set_ph = 1'b1;
				op_d.phase  = item.phase_value;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (move) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op_d;
		end
	end

	assign push_valid = vld_s1;
	assign push_op    = op_s1;

endmodule

`default_nettype wire

>>> rtl/core/cstl_queue.sv
// short queue between front and back ends
`default_nettype none

module cstl_queue import cstl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  op_t   push_op,
	output logic  push_ready,
	output logic  pop_valid,
	output op_t   pop_op,
	input  logic  pop_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t               entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_op     = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/cstl_back.sv
// back end: phase state update, waveform shaping and result register
`default_nettype none

module cstl_back import cstl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_info_t   info,
	input  logic        pop_valid,
	input  op_t         pop_op,
	output logic        pop_ready,
	cstl_out_if.source  result
);

	localparam int DIFF_W = PHASE_W + 2;
	localparam logic signed [PHASE_W-1:0] SNAP_P = SNAP_LIMIT;
	localparam logic signed [PHASE_W-1:0] SNAP_N = -SNAP_P;
	localparam logic signed [DIFF_W-1:0]  DSNAP_P = DIFF_W'(SNAP_LIMIT);
	localparam logic signed [DIFF_W-1:0]  DSNAP_N = -DSNAP_P;

	logic [PHASE_W-1:0]  main_q;
	logic [PHASE_W-1:0]  syn_q;
	logic [ECNT_W-1:0]   ecnt_q;
	logic                off_hi_q;
	logic                off_lo_q;

	logic                vld_s1;
	logic [PHASE_W-1:0]  ph_s1;
	logic                out_vld_q;
	logic [PHASE_W-1:0]  tri_q;
	logic                sq_q;

	logic                en;
	logic                exec;
	logic [PHASE_W-1:0]  inc_ext;
	logic [PHASE_W-1:0]  step_sel;
	logic [PHASE_W-1:0]  main_plain;
	logic [PHASE_W-1:0]  main_corr;
	logic [PHASE_W-1:0]  syn_adv;
	logic [PHASE_W-1:0]  hm;
	logic [PHASE_W-1:0]  hs;
	logic signed [DIFF_W-1:0] diff;
	logic                close;

	logic [PHASE_W-1:0]  main_n;
	logic [PHASE_W-1:0]  syn_n;
	logic [ECNT_W-1:0]   ecnt_n;
	logic                off_hi_n;
	logic                off_lo_n;

	function automatic logic [PHASE_W-1:0] tri_of(input logic [PHASE_W-1:0] p);
		logic [PHASE_W-1:0] t;
		// negative half rises, positive half falls, both doubled
		if (p[PHASE_W-1]) begin
			t = {~p[PHASE_W-2], p[PHASE_W-3:0], 1'b0};
		end else begin
			t = PHASE_MIN - {p[PHASE_W-2:0], 1'b0};
		end
		return t;
	endfunction

	assign en        = !out_vld_q || result.ready;
	assign pop_ready = en;
	assign exec      = pop_valid && en;

	always_comb begin
		inc_ext  = PHASE_W'(info.inc);
		// offset ahead gives a full extra step, behind backs off (or steps)
		if (off_hi_q) begin
			step_sel = info.step_fast;
		end else if (off_lo_q) begin
			step_sel = info.step_slow;
		end else begin
			step_sel = inc_ext;
		end
		main_plain = main_q + inc_ext;
		main_corr  = main_q + step_sel;
		syn_adv    = syn_q + inc_ext;

		// halves truncated towards zero, compared as a signed distance
		hm   = PHASE_W'($signed(main_corr) >>> 1);
		hs   = PHASE_W'($signed(syn_adv) >>> 1);
		diff = $signed({{2{hm[PHASE_W-1]}}, hm}) - $signed({{2{hs[PHASE_W-1]}}, hs})
			+ $signed(DIFF_W'(main_corr[PHASE_W-1] & main_corr[0]))
			- $signed(DIFF_W'(syn_adv[PHASE_W-1] & syn_adv[0]));
		close = (diff < DSNAP_P) && (diff > DSNAP_N);
	end

	always_comb begin
		main_n   = main_q;
		syn_n    = syn_q;
		ecnt_n   = ecnt_q;
		off_hi_n = off_hi_q;
		off_lo_n = off_lo_q;
		priority if (pop_op.sample) begin
			if (info.corr_en) begin
				syn_n = syn_adv;
				if (close) begin
					// snap to the clock-locked phase, offset cleared
					main_n   = syn_adv;
					off_hi_n = 1'b0;
					off_lo_n = 1'b0;
				end else begin
					main_n = main_corr;
				end
			end else begin
				main_n = main_plain;
			end
		end else if (pop_op.clk_edge) begin
			if (info.sync) begin
				if (ecnt_q >= info.delay) begin
					off_hi_n = $signed(main_q) >= SNAP_P;
					off_lo_n = $signed(main_q) <= SNAP_N;
					syn_n    = PHASE_MIN;
					ecnt_n   = ECNT_W'(1);
				end else if (ecnt_q != ECNT_MAX) begin
					ecnt_n = ecnt_q + 1'b1;
				end
			end
		end else if (pop_op.rst_ph) begin
			main_n = PHASE_MIN;
			syn_n  = PHASE_MIN;
		end else begin
			main_n = pop_op.phase;
			syn_n  = pop_op.phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q    <= PHASE_MIN;
			syn_q     <= PHASE_MIN;
			ecnt_q    <= '0;
			off_hi_q  <= 1'b0;
			off_lo_q  <= 1'b0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (exec) begin
				main_q   <= main_n;
				syn_q    <= syn_n;
				ecnt_q   <= ecnt_n;
				off_hi_q <= off_hi_n;
				off_lo_q <= off_lo_n;
			end
			if (en) begin
				vld_s1    <= exec;
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			ph_s1 <= main_n;
		end
		if (en && vld_s1) begin
			tri_q <= tri_of(ph_s1);
			sq_q  <= ph_s1[PHASE_W-1];
		end
	end

	assign result.valid    = out_vld_q;
	assign result.triangle = tri_q;
	assign result.square   = sq_q;

endmodule

`default_nettype wire

>>> rtl/core/clock_synced_triangle_lfo.sv
// top level of the clock-synced triangle lfo
//
// channels: item_in carries a command (sample, clock edge, reset phase, set
// phase) and a signed q31 phase value; result_out returns one triangle value
// and one square bit per command, taken from the phase after that command.
// cfg writes one register per transfer (index, data).
// throughput: one command per cycle while cfg is idle and result_out is not
// stalled; the phase update is a loop around the phase registers in the back end,
// fed from a two-entry queue behind the classifying front. a command passes
// the front register, the queue, the phase stage and then the result register.
// a register write takes cfg.ready and item_in.ready low while the increment
// is rebuilt, in sync mode by the shared iterative divider (up to two 31-step
// divisions), in free-running mode without the divider.
// reset: all registers return to their defaults, both phases to the most
// negative value and the increment to its reset-derived value at once, so
// commands are taken straight after reset.
// a stalled result_out holds the result register; the queue then fills and
// item_in.ready drops, without losing or repeating any result.
`default_nettype none

`include "assert_macros.svh"

module clock_synced_triangle_lfo import cstl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cstl_in_if.sink     item_in,
	cstl_out_if.source  result_out,
	cstl_cfg_if.sink    cfg
);

	cfg_info_t  cfg_info;
	logic       cfg_busy;

	logic       q_push_valid;
	op_t        q_push_op;
	logic       q_push_ready;
	logic       q_pop_valid;
	op_t        q_pop_op;
	logic       q_pop_ready;

	// registers, derived settings and the increment divider
	cstl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.info   (cfg_info),
		.busy   (cfg_busy)
	);

	// command intake and decode
	cstl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_in),
		.busy       (cfg_busy),
		.push_valid (q_push_valid),
		.push_op    (q_push_op),
		.push_ready (q_push_ready)
	);

	// decouples intake from the phase loop
	cstl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_op    (q_push_op),
		.push_ready (q_push_ready),
		.pop_valid  (q_pop_valid),
		.pop_op     (q_pop_op),
		.pop_ready  (q_pop_ready)
	);

	// phase accumulators, sync correction and output shaping
	cstl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.info      (cfg_info),
		.pop_valid (q_pop_valid),
		.pop_op    (q_pop_op),
		.pop_ready (q_pop_ready),
		.result    (result_out)
	);

	// a register transfer must hold off commands until the increment is rebuilt
	`CSTL_ASSERT_NEXT(a_cfg_blocks_items, clk, arst_n, cfg.valid && cfg.ready, !item_in.ready)

	// once settled, the fast step is exactly twice the increment
	`CSTL_ASSERT_IMPLIES(a_steps_settled, clk, arst_n, !cfg_busy,
		(cfg_info.step_fast == {cfg_info.inc, 1'b0}))

	// the triangle is a doubled value, so its lowest bit is always clear
	`CSTL_ASSERT_IMPLIES(a_tri_even, clk, arst_n, result_out.valid, !result_out.triangle[0])

endmodule

`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for the clock-synced triangle lfo: directed and random commands
`default_nettype none

module tb_top;
	import cstl_pkg::*;

	// one command as it waits for the driver
	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [PHASE_W-1:0] phase;
	} lfo_cmd_t;

	// one result as the phase predictor works it out
	typedef struct packed {
		logic [PHASE_W-1:0] triangle;
		logic               square;
	} lfo_out_t;

	localparam longint     SNAP_T       = 64'h7FFF_FFFF / 40;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam int         CYCLE_LIMIT  = 300000;
	localparam int         ITEM_TARGET  = 500;

	logic clk;
	logic arst_n;

	cstl_in_if  cmd_ch ();
	cstl_out_if res_ch ();
	cstl_cfg_if reg_ch ();

	clock_synced_triangle_lfo dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (cmd_ch),
		.result_out (res_ch),
		.cfg        (reg_ch)
	);

	// free-running clock, period 12
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// shadow copy of the register file
	logic                cfg_sync;
	logic [INC_W-1:0]    cfg_free;
	logic [TICKS_W-1:0]  cfg_ticks;
	logic [RATIO_W-1:0]  cfg_num;
	logic [RATIO_W-1:0]  cfg_den;
	logic                cfg_no_slow;
	logic [TICKS_W-1:0]  cfg_min_ticks;

	// shadow copy of the phase state
	logic [PHASE_W-1:0]  main_ph;
	logic [PHASE_W-1:0]  sync_ph;
	logic [PHASE_W-1:0]  held_offset;
	logic [ECNT_W-1:0]   edge_count;
	logic [PHASE_W-1:0]  phase_step;

	lfo_cmd_t cmd_backlog[$];   // commands not yet handed to the driver
	lfo_out_t result_due[$];    // predicted results, oldest first

	logic steady;               // no idling on either side once set
	int   items_sent;
	int   results_seen;
	int   regs_written;
	int   fails;
	int   cycles;

	// ratio terms of zero count as one, anything past the maximum is clipped
	function automatic int unsigned ratio_clamp(input logic [RATIO_W-1:0] r);
		if (r == '0)
			return 1;
		if (r > RATIO_MAX)
			return RATIO_MAX;
		return r;
	endfunction

	// step size follows the clock ratio in synced mode, the register otherwise
	function automatic void rebuild_step();
		longint unsigned n, d, span, half;
		if (cfg_sync) begin
			n    = ratio_clamp(cfg_num);
			d    = ratio_clamp(cfg_den);
			span = (64'(cfg_ticks) * d) / n;
			half = span / 2;
			// a zero divisor saturates the step
			phase_step = (half == 0) ? 32'h7FFF_FFFF : 32'(64'h7FFF_FFFF / half);
		end else begin
			phase_step = {1'b0, cfg_free};
		end
	endfunction

	function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_SYNC_MODE:   cfg_sync = val[0];
			REG_FREE_INC:    cfg_free = val[INC_W-1:0];
			REG_CLOCK_TICKS: cfg_ticks = (val[TICKS_W-1:0] == '0) ? 20'd1 : val[TICKS_W-1:0];
			REG_RATIO_NUM:   cfg_num = val[RATIO_W-1:0];
			REG_RATIO_DEN:   cfg_den = val[RATIO_W-1:0];
			REG_NO_SLOWDOWN: cfg_no_slow = val[0];
			REG_MIN_TICKS:   cfg_min_ticks = val[TICKS_W-1:0];
			default: return;
		endcase
		rebuild_step();
	endfunction

	// advances the shadow phase by one command and returns its result
	function automatic lfo_out_t lfo_advance(input logic [CMD_W-1:0] op,
			input logic [PHASE_W-1:0] pv);
		logic [PHASE_W-1:0] inc;
		longint             off, m_half, s_half, gap;
		int unsigned        n, d, delay;
		lfo_out_t           r;
		inc = phase_step;
		case (op)
			CMD_SAMPLE: begin
				main_ph = main_ph + inc;
				if (cfg_sync && cfg_ticks > cfg_min_ticks) begin
					off = $signed(held_offset);
					sync_ph = sync_ph + inc;
					// the offset latched at the last restart decides the nudge
					if (off >= SNAP_T) begin
						main_ph = main_ph + inc;
					end else if (off <= -SNAP_T) begin
						if (cfg_no_slow)
							main_ph = main_ph + inc;
						else
							main_ph = main_ph - (inc >> 1);
					end
					// halves truncate towards zero before the distance is taken
					m_half = $signed(main_ph);
					s_half = $signed(sync_ph);
					m_half = m_half / 2;
					s_half = s_half / 2;
					gap = m_half - s_half;
					if (gap < 0)
						gap = -gap;
					if (gap < SNAP_T) begin
						main_ph = sync_ph;
						held_offset = '0;
					end
				end
			end
			CMD_CLOCK: begin
				if (cfg_sync) begin
					n = ratio_clamp(cfg_num);
					d = ratio_clamp(cfg_den);
					delay = (d == 1) ? 1 : n * d;
					if (delay > ECNT_MAX)
						delay = ECNT_MAX;
					if (edge_count >= delay) begin
						held_offset = main_ph;
						sync_ph = PHASE_MIN;
						edge_count = '0;
					end
					if (edge_count < ECNT_MAX)
						edge_count = edge_count + 1'b1;
				end
			end
			CMD_RESET: begin
				main_ph = PHASE_MIN;
				sync_ph = PHASE_MIN;
			end
			default: begin
				main_ph = pv;
				sync_ph = pv;
			end
		endcase
		r.square = main_ph[PHASE_W-1];
		if (r.square)
			r.triangle = (main_ph + QUARTER_TURN) << 1;
		else
			r.triangle = (QUARTER_TURN - main_ph) << 1;
		return r;
	endfunction

	// command driver: predicts on every transfer, then offers the next command
	// or idles for a burst when one is drawn
	int hold_off;

	always @(posedge clk) begin : drive
		lfo_cmd_t nxt;
		if (!arst_n) begin
			cmd_ch.valid       <= 1'b0;
			cmd_ch.command     <= CMD_SAMPLE;
			cmd_ch.phase_value <= '0;
			hold_off = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				result_due.push_back(lfo_advance(cmd_ch.command, cmd_ch.phase_value));
			// the slot is free when nothing is offered or the offer just went through
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (hold_off > 0) begin
					hold_off = hold_off - 1;
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					nxt = cmd_backlog.pop_front();
					cmd_ch.valid       <= 1'b1;
					cmd_ch.command     <= nxt.op;
					cmd_ch.phase_value <= nxt.phase;
					if (!steady && $urandom_range(0, 5) == 0)
						hold_off = $urandom_range(1, 12);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each transfer against the oldest prediction and
	// back-pressures in random bursts
	int stall_left;

	always @(posedge clk) begin : watch
		lfo_out_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen = results_seen + 1;
				if (result_due.size() == 0) begin
					$error("result with nothing predicted: triangle %h square %b",
						res_ch.triangle, res_ch.square);
					fails = fails + 1;
				end else begin
					want = result_due.pop_front();
					if (res_ch.triangle !== want.triangle) begin
						$error("triangle: expected %h, got %h", want.triangle, res_ch.triangle);
						fails = fails + 1;
					end
					if (res_ch.square !== want.square) begin
						$error("square: expected %b, got %b", want.square, res_ch.square);
						fails = fails + 1;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				res_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results still awaited", cycles,
				result_due.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [PHASE_W-1:0] pv);
		lfo_cmd_t c;
		c.op    = op;
		c.phase = pv;
		cmd_backlog.push_back(c);
		items_sent = items_sent + 1;
	endtask

	// waits until every command has gone through and every result is back
	task automatic settle();
		@(posedge clk);
		while (cmd_backlog.size() != 0 || cmd_ch.valid || result_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// one register transfer; junk above the field width must be ignored
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val,
			input int width);
		logic [31:0] word;
		word = val;
		if ($urandom_range(0, 1) == 1)
			word = word | ($urandom << width);
		@(posedge clk);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data  <= word;
		@(posedge clk);
		while (!reg_ch.ready)
			@(posedge clk);
		store_reg(idx, word);
		regs_written = regs_written + 1;
		reg_ch.valid <= 1'b0;
	endtask

	task automatic program_regs(input logic [31:0] sync, input logic [31:0] free_inc,
			input logic [31:0] ticks, input logic [31:0] num, input logic [31:0] den,
			input logic [31:0] no_slow, input logic [31:0] min_ticks);
		settle();
		write_reg(REG_SYNC_MODE, sync, 1);
		write_reg(REG_FREE_INC, free_inc, INC_W);
		write_reg(REG_CLOCK_TICKS, ticks, TICKS_W);
		write_reg(REG_RATIO_NUM, num, RATIO_W);
		write_reg(REG_RATIO_DEN, den, RATIO_W);
		write_reg(REG_NO_SLOWDOWN, no_slow, 1);
		write_reg(REG_MIN_TICKS, min_ticks, TICKS_W);
	endtask

	// mostly samples with clock edges at a rough beat near the clock period,
	// sprinkled with stray edges, phase resets and phase loads
	task automatic run_phase(input int count);
		int spacing, since_edge, pick;
		spacing = (cfg_ticks < 24) ? int'(cfg_ticks) : int'($urandom_range(3, 24));
		since_edge = 0;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				push_cmd(CMD_SET, $urandom);
			end else if (pick < 5) begin
				push_cmd(CMD_RESET, $urandom);
			end else if (pick < 9 || since_edge >= spacing) begin
				push_cmd(CMD_CLOCK, $urandom);
				since_edge = $urandom_range(0, 2);
			end else begin
				push_cmd(CMD_SAMPLE, $urandom);
				since_edge = since_edge + 1;
			end
		end
	endtask

	initial begin : stimulus
		logic [31:0] r_sync, r_free, r_ticks, r_num, r_den, r_slow, r_min;
		// every input known from time zero, reset asserted at the start
		arst_n             = 1'b0;
		steady             = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.command     = CMD_SAMPLE;
		cmd_ch.phase_value = '0;
		res_ch.ready       = 1'b0;
		reg_ch.valid       = 1'b0;
		reg_ch.index       = REG_SYNC_MODE;
		reg_ch.data        = '0;
		items_sent   = 0;
		results_seen = 0;
		regs_written = 0;
		fails        = 0;
		cycles       = 0;

		// shadow state as the block comes out of reset
		cfg_sync      = 1'b1;
		cfg_free      = '0;
		cfg_ticks     = RST_TICKS;
		cfg_num       = RST_RATIO;
		cfg_den       = RST_RATIO;
		cfg_no_slow   = 1'b0;
		cfg_min_ticks = RST_MIN_TICKS;
		main_ph       = PHASE_MIN;
		sync_ph       = PHASE_MIN;
		held_offset   = '0;
		edge_count    = '0;
		rebuild_step();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, phase extremes, unused phase values
		push_cmd(CMD_SAMPLE, 32'h0000_0000);
		push_cmd(CMD_SAMPLE, 32'hFFFF_FFFF);
		push_cmd(CMD_CLOCK,  32'hA5A5_5A5A);
		push_cmd(CMD_CLOCK,  32'h5A5A_A5A5);
		push_cmd(CMD_SAMPLE, 32'h0000_0000);
		push_cmd(CMD_SET,    32'h7FFF_FFFF);
		push_cmd(CMD_SAMPLE, 32'h0000_0000);
		push_cmd(CMD_SET,    32'h8000_0000);
		push_cmd(CMD_SET,    32'h0000_0000);
		push_cmd(CMD_SET,    32'h4000_0000);
		push_cmd(CMD_SET,    32'hC000_0000);
		push_cmd(CMD_SET,    32'hFFFF_FFFF);
		push_cmd(CMD_SET,    32'h0000_0001);
		push_cmd(CMD_SAMPLE, 32'h8000_0000);
		push_cmd(CMD_RESET,  32'hFFFF_FFFF);
		push_cmd(CMD_SET,    32'h3FFF_FFFF);
		// restart latches a large positive offset, so the samples after it speed up
		push_cmd(CMD_CLOCK,  32'h0000_0000);
		push_cmd(CMD_SAMPLE, 32'h7FFF_FFFF);
		push_cmd(CMD_SAMPLE, 32'h0000_0000);
		push_cmd(CMD_SET,    32'hC000_0001);
		push_cmd(CMD_CLOCK,  32'hFFFF_FFFF);
		push_cmd(CMD_SAMPLE, 32'h0000_0000);
		push_cmd(CMD_RESET,  32'h1234_5678);
		push_cmd(CMD_SAMPLE, 32'h0000_0000);

		// zero clock period and zero ratio terms: the divisor vanishes
		program_regs(1, 0, 0, 0, 0, 1, 0);
		run_phase(30);
		// tight beat, unit ratio, half-step backoff
		program_regs(1, 32'h7FFF_FFFF, 16, 1, 1, 0, 0);
		run_phase(30);
		// longest period, clipped denominator, correction held off
		program_regs(1, 0, 20'hF_FFFF, 1, 127, 0, 20'hF_FFFF);
		run_phase(30);
		// largest ratio terms give the longest restart delay
		program_regs(1, 1, 20, 127, 64, 1, 4);
		run_phase(30);
		// free-running at the largest and the smallest step
		program_regs(0, 32'h7FFF_FFFF, 1, 64, 1, 1, 20'hF_FFFF);
		run_phase(30);
		program_regs(0, 0, 500, 1, 1, 0, 4);
		run_phase(20);
		// uneven ratio with a full extra step in place of the backoff
		program_regs(1, 0, 12, 2, 3, 1, 2);
		run_phase(30);

		// random settings, mostly short periods and small ratios
		while (items_sent < ITEM_TARGET) begin
			r_sync = ($urandom_range(0, 3) != 0);
			r_free = $urandom & 32'h7FFF_FFFF;
			pick_ticks: begin
				int sel;
				sel = $urandom_range(0, 9);
				if (sel == 0)
					r_ticks = $urandom & 32'h000F_FFFF;
				else if (sel < 3)
					r_ticks = $urandom_range(65, 2000);
				else
					r_ticks = $urandom_range(2, 40);
			end
			r_num  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 127);
			r_den  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 127);
			r_slow = $urandom_range(0, 1);
			r_min  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : ($urandom & 32'hF_FFFF);
			// the closing stretch runs with both sides always willing
			if (items_sent >= ITEM_TARGET - 60)
				steady = 1'b1;
			program_regs(r_sync, r_free, r_ticks, r_num, r_den, r_slow, r_min);
			run_phase($urandom_range(25, 45));
		end

		settle();
		$display("covered %0d commands across %0d register transfers in %0d cycles",
			items_sent, regs_written, cycles);
		$display("%0d results compared with the predicted phase, %0d failures",
			results_seen, fails);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
